// ===== src/json_string_unescape_macros.svh =====
// Assertion macros shared by the RTL of the JSON string decoder.
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

// Checked at every rising edge of clk outside reset.
`define JSU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define JSU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/jsu_pkg.sv =====
`default_nettype none
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_BODY = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX0 = 3'd3,
    MODE_HEX1 = 3'd4,
    MODE_HEX2 = 3'd5,
    MODE_HEX3 = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    KIND_UNIT  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] unit;
    logic [15:0] count;
  } result_t;

  localparam logic [15:0] CTRL_MAX  = 16'h001F;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic [15:0] CH_QUOTE     = 16'h0022;
  localparam logic [15:0] CH_BACKSLASH = 16'h005C;
  localparam logic [15:0] CH_SLASH     = 16'h002F;
  localparam logic [15:0] CH_B         = 16'h0062;
  localparam logic [15:0] CH_F         = 16'h0066;
  localparam logic [15:0] CH_N         = 16'h006E;
  localparam logic [15:0] CH_R         = 16'h0072;
  localparam logic [15:0] CH_T         = 16'h0074;
  localparam logic [15:0] CH_U         = 16'h0075;

  localparam logic [15:0] UNIT_BS  = 16'h0008;
  localparam logic [15:0] UNIT_FF  = 16'h000C;
  localparam logic [15:0] UNIT_LF  = 16'h000A;
  localparam logic [15:0] UNIT_CR  = 16'h000D;
  localparam logic [15:0] UNIT_TAB = 16'h0009;

  // Digit value in the low four bits; bit 4 set means not a hex digit.
  localparam logic [4:0] HEX_BAD = 5'd16;

  function automatic logic [4:0] hex_value(input logic [15:0] c);
    logic [4:0] v;
    begin
      v = HEX_BAD;
      if (c >= 16'h0030 && c <= 16'h0039) begin
        v = 5'(c - 16'h0030);
      end else if (c >= 16'h0061 && c <= 16'h0066) begin
        v = 5'(c - 16'h0061 + 16'd10);
      end else if (c >= 16'h0041 && c <= 16'h0046) begin
        v = 5'(c - 16'h0041 + 16'd10);
      end
      return v;
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/json_string_unescape.sv =====
// A result is registered into the output buffer and shows on out_valid from its main entry.
// Throughput: one code unit per cycle while in_stall is low; the parse state updates in a single step per unit.
// A two-entry output buffer keeps input flowing while one result waits on out_stall.
// Reset (rst, synchronous) returns the parser to idle, clears the hex value and the
// count, and empties the output buffer.
`default_nettype none
`include "json_string_unescape_macros.svh"
module json_string_unescape (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] code_unit,
  input  wire logic        at_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output jsu_pkg::kind_t   result_kind,
  output logic [15:0]      decoded_unit,
  output logic [15:0]      units_consumed
);
  import jsu_pkg::*;

  mode_t       mode, mode_next;
  logic [15:0] hex_acc, hex_acc_next;
  logic [15:0] count, count_next;

  logic    res_valid;
  result_t res;

  result_t main_res, skid_res;
  logic    main_valid, skid_valid;

  logic accept, drain;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign drain    = main_valid && !out_stall;

  // Parse step for one unit.
  always_comb begin
    logic [15:0] count_inc;
    logic [4:0]  hv;
    count_inc    = (count == COUNT_MAX) ? count : count + 16'd1;
    hv           = hex_value(code_unit);
    mode_next    = mode;
    hex_acc_next = hex_acc;
    count_next   = count;
    res_valid    = 1'b0;
    res          = '{kind: KIND_ERROR, unit: 16'd0, count: 16'd0};

    if (at_end) begin
      mode_next    = MODE_IDLE;
      hex_acc_next = 16'd0;
      count_next   = 16'd0;
      res_valid    = 1'b1;
    end else begin
      unique case (mode)
        MODE_BODY: begin
          count_next = count_inc;
          if (code_unit == CH_QUOTE) begin
            mode_next    = MODE_IDLE;
            hex_acc_next = 16'd0;
            count_next   = 16'd0;
            res_valid    = 1'b1;
            res          = '{kind: KIND_DONE, unit: 16'd0, count: count_inc};
          end else if (code_unit == CH_BACKSLASH) begin
            mode_next = MODE_ESC;
          end else if (code_unit > CTRL_MAX) begin
            res_valid = 1'b1;
            res       = '{kind: KIND_UNIT, unit: code_unit, count: 16'd0};
          end else begin
            mode_next    = MODE_IDLE;
            hex_acc_next = 16'd0;
            count_next   = 16'd0;
            res_valid    = 1'b1;
          end
        end
        MODE_ESC: begin
          count_next = count_inc;
          mode_next  = MODE_BODY;
          res_valid  = 1'b1;
          res.kind   = KIND_UNIT;
          unique case (code_unit)
            CH_QUOTE, CH_BACKSLASH, CH_SLASH: res.unit = code_unit;
            CH_B: res.unit = UNIT_BS;
            CH_F: res.unit = UNIT_FF;
            CH_N: res.unit = UNIT_LF;
            CH_R: res.unit = UNIT_CR;
            CH_T: res.unit = UNIT_TAB;
            CH_U: begin
              mode_next    = MODE_HEX0;
              hex_acc_next = 16'd0;
              res_valid    = 1'b0;
            end
            default: begin
              mode_next    = MODE_IDLE;
              hex_acc_next = 16'd0;
              count_next   = 16'd0;
              res.kind     = KIND_ERROR;
            end
          endcase
        end
        MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
          count_next = count_inc;
          if (hv[4]) begin
            mode_next    = MODE_IDLE;
            hex_acc_next = 16'd0;
            count_next   = 16'd0;
            res_valid    = 1'b1;
          end else if (mode == MODE_HEX3) begin
            mode_next    = MODE_BODY;
            hex_acc_next = 16'd0;
            res_valid    = 1'b1;
            res          = '{kind: KIND_UNIT, unit: {hex_acc[11:0], hv[3:0]},
                             count: 16'd0};
          end else begin
            mode_next    = mode_t'(mode + 3'd1);
            hex_acc_next = {hex_acc[11:0], hv[3:0]};
          end
        end
        default: begin
          // Idle, and the unused mode code, wait for the opening quote.
          if (code_unit == CH_QUOTE) begin
            mode_next    = MODE_BODY;
            hex_acc_next = 16'd0;
            count_next   = 16'd1;
          end else begin
            mode_next    = MODE_IDLE;
            hex_acc_next = 16'd0;
            count_next   = 16'd0;
            res_valid    = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      hex_acc <= 16'd0;
      count   <= 16'd0;
    end else if (accept) begin
      mode    <= mode_next;
      hex_acc <= hex_acc_next;
      count   <= count_next;
    end
  end

  // Output buffer: the skid entry only fills while the main entry is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid) begin
        main_res <= skid_res;
      end else if (accept && res_valid) begin
        main_res <= res;
      end
    end else if (accept && res_valid) begin
      if (main_valid) begin
        skid_res <= res;
      end else begin
        main_res <= res;
      end
    end
  end

  assign out_valid      = main_valid;
  assign result_kind    = main_res.kind;
  assign decoded_unit   = main_res.unit;
  assign units_consumed = main_res.count;

  `JSU_ASSERT(a_skid_needs_main, skid_valid |-> main_valid, "skid entry filled while main empty")
  `JSU_ASSERT(a_skid_drains, (skid_valid && !out_stall) |=> !skid_valid,
              "skid entry not moved up after a drain")
  `JSU_ASSERT(a_count_in_string, (mode != MODE_IDLE) |-> (count != 16'd0),
              "unit count zero inside a string")
  `JSU_ASSERT(a_done_count, (out_valid && result_kind == KIND_DONE) |-> (units_consumed >= 16'd2),
              "done transaction with fewer than two units")
  `JSU_ASSERT(a_non_unit_zero, (out_valid && result_kind != KIND_UNIT) |-> (decoded_unit == 16'd0),
              "decoded unit nonzero on done or error")
  `JSU_ASSERT_ALWAYS(a_reset_empty, rst |=> (!out_valid && !in_stall),
                     "output buffer not empty after reset")

endmodule
`default_nettype wire
